### hdl/kthanc_pkg.sv
// ----------------------------------------------------------------------------
// kthanc_pkg
// Sizes, field layout and address helper for the kth-ancestor block.
// ----------------------------------------------------------------------------
package kthanc_pkg;

	// Tree size and lifting depth
	localparam int NODES  = 1024;
	localparam int LEVELS = 11;

	// Field widths of the stream items
	localparam int NODE_W  = 11;
	localparam int STEPS_W = 16;

	// Derived storage widths
	localparam int IDX_W   = $clog2(NODES);
	localparam int LVL_W   = $clog2(LEVELS);
	localparam int DEPTH   = NODES * LEVELS;
	localparam int ADDR_W  = $clog2(DEPTH);

	// Stream packing: node, parent, steps from bit 0 up
	localparam int NODE_LSB   = 0;
	localparam int PARENT_LSB = NODE_LSB + NODE_W;
	localparam int STEPS_LSB  = PARENT_LSB + NODE_W;
	localparam int IN_BITS    = STEPS_LSB + STEPS_W;
	localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((NODE_W + 7) / 8) * 8;

	// Item kinds carried in tuser
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// Table address: one block of NODES entries per level
	function automatic logic [ADDR_W-1:0] mem_addr(input logic [LVL_W-1:0] lvl,
			input logic [IDX_W-1:0] idx);
		logic [ADDR_W-1:0] base;
		base = ADDR_W'(lvl) * ADDR_W'(NODES);
		return base + ADDR_W'(idx);
	endfunction

endpackage

### hdl/kth_ancestor_binary_lifting.sv
// ----------------------------------------------------------------------------
// kth_ancestor_binary_lifting
// Load beat: its parent entry is written as it is taken; the block stays ready.
// Query on a current table: the walk visits the levels from the top down, with
// a table load per set step bit, then the result loads and the block is ready.
// First query after reset or loads rebuilds levels 1..LEVELS-1 first, with
// three RAM accesses per entry. A held result delays the answer.
// Reset: a clearing pass zeroes every level-0 entry; no input taken meanwhile.
// ----------------------------------------------------------------------------
module kth_ancestor_binary_lifting (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [kthanc_pkg::IN_DATA_W-1:0]    s_tdata,   // node, parent, steps, zero pad
	input  logic                                s_tuser,   // kind
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [kthanc_pkg::OUT_DATA_W-1:0]   m_tdata    // ancestor, zero pad
);

	typedef enum logic [7:0] {
		S_CLEAR  = 8'b0000_0001,
		S_IDLE   = 8'b0000_0010,
		S_RB_RD1 = 8'b0000_0100,
		S_RB_RD2 = 8'b0000_1000,
		S_RB_WR  = 8'b0001_0000,
		S_Q_STEP = 8'b0010_0000,
		S_Q_LOAD = 8'b0100_0000,
		S_Q_DONE = 8'b1000_0000
	} state_t;

	localparam logic [kthanc_pkg::NODE_W-1:0] NODE_MAX =
		kthanc_pkg::NODE_W'(kthanc_pkg::NODES);
	localparam logic [kthanc_pkg::IDX_W-1:0] IDX_LAST =
		kthanc_pkg::IDX_W'(kthanc_pkg::NODES - 1);
	localparam logic [kthanc_pkg::LVL_W-1:0] LVL_TOP =
		kthanc_pkg::LVL_W'(kthanc_pkg::LEVELS - 1);

	state_t                              state_q;
	logic                                stale_q;
	logic [kthanc_pkg::IDX_W-1:0]        idx_q;
	logic [kthanc_pkg::LVL_W-1:0]        lvl_q;
	logic [kthanc_pkg::NODE_W-1:0]       x_q;
	logic [kthanc_pkg::STEPS_W-1:0]      steps_q;
	logic                                mid_zero_q;
	logic [kthanc_pkg::NODE_W-1:0]       rd_data_q;
	logic                                m_tvalid_q;
	logic [kthanc_pkg::NODE_W-1:0]       m_data_q;

	logic [kthanc_pkg::NODE_W-1:0]       mem [kthanc_pkg::DEPTH];

	// Input field split
	logic [kthanc_pkg::NODE_W-1:0]       in_node;
	logic [kthanc_pkg::NODE_W-1:0]       in_parent;
	logic [kthanc_pkg::STEPS_W-1:0]      in_steps;
	logic                                in_node_ok;
	logic                                steps_big;
	logic                                accept;
	logic                                step_bit;
	logic                                out_free;

	// RAM port controls
	logic                                we;
	logic [kthanc_pkg::ADDR_W-1:0]       waddr;
	logic [kthanc_pkg::NODE_W-1:0]       wdata;
	logic                                re;
	logic [kthanc_pkg::ADDR_W-1:0]       raddr;

	assign in_node   = s_tdata[kthanc_pkg::NODE_LSB +: kthanc_pkg::NODE_W];
	assign in_parent = s_tdata[kthanc_pkg::PARENT_LSB +: kthanc_pkg::NODE_W];
	assign in_steps  = s_tdata[kthanc_pkg::STEPS_LSB +: kthanc_pkg::STEPS_W];

	assign in_node_ok = (in_node != '0) && (in_node <= NODE_MAX);
	assign steps_big  = (in_steps >> kthanc_pkg::LEVELS) != '0;
	assign s_tready   = (state_q == S_IDLE);
	assign accept     = s_tvalid && s_tready;
	assign step_bit   = ((steps_q >> lvl_q) & kthanc_pkg::STEPS_W'(1)) != '0;
	assign out_free   = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = kthanc_pkg::OUT_DATA_W'(m_data_q);

	// RAM address and write data per state
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		re    = 1'b0;
		raddr = '0;
		unique case (state_q)
			S_CLEAR: begin
				we    = 1'b1;
				waddr = kthanc_pkg::mem_addr('0, idx_q);
			end
			S_IDLE: begin
				// parent entry write; out-of-range parent means root
				we    = accept && (s_tuser == kthanc_pkg::KIND_LOAD) && in_node_ok;
				waddr = kthanc_pkg::mem_addr('0,
					kthanc_pkg::IDX_W'(in_node - kthanc_pkg::NODE_W'(1)));
				wdata = (in_parent > NODE_MAX) ? '0 : in_parent;
			end
			S_RB_RD1: begin
				re    = 1'b1;
				raddr = kthanc_pkg::mem_addr(lvl_q - kthanc_pkg::LVL_W'(1), idx_q);
			end
			S_RB_RD2: begin
				re    = 1'b1;
				raddr = kthanc_pkg::mem_addr(lvl_q - kthanc_pkg::LVL_W'(1),
					kthanc_pkg::IDX_W'(rd_data_q - kthanc_pkg::NODE_W'(1)));
			end
			S_RB_WR: begin
				we    = 1'b1;
				waddr = kthanc_pkg::mem_addr(lvl_q, idx_q);
				wdata = mid_zero_q ? '0 : rd_data_q;
			end
			S_Q_STEP: begin
				re    = (x_q != '0) && step_bit;
				raddr = kthanc_pkg::mem_addr(lvl_q,
					kthanc_pkg::IDX_W'(x_q - kthanc_pkg::NODE_W'(1)));
			end
			S_Q_LOAD, S_Q_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// Jump table RAM, registered read
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rd_data_q <= mem[raddr];
	end

	// Result register: loads when the answer is ready, clears when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			m_data_q   <= '0;
		end else if (state_q == S_Q_DONE && out_free) begin
			m_data_q   <= x_q;
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			stale_q    <= 1'b1;
			idx_q      <= '0;
			lvl_q      <= '0;
			x_q        <= '0;
			steps_q    <= '0;
			mid_zero_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					idx_q <= idx_q + kthanc_pkg::IDX_W'(1);
					if (idx_q == IDX_LAST) begin
						idx_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (s_tuser == kthanc_pkg::KIND_LOAD) begin
							if (in_node_ok)
								stale_q <= 1'b1;
						end else begin
							x_q     <= (in_node_ok && !steps_big) ? in_node : '0;
							steps_q <= in_steps;
							idx_q   <= '0;
							if (stale_q) begin
								lvl_q   <= kthanc_pkg::LVL_W'(1);
								state_q <= S_RB_RD1;
							end else begin
								lvl_q   <= LVL_TOP;
								state_q <= S_Q_STEP;
							end
						end
					end
				end
				S_RB_RD1: begin
					state_q <= S_RB_RD2;
				end
				S_RB_RD2: begin
					mid_zero_q <= (rd_data_q == '0);
					state_q    <= S_RB_WR;
				end
				S_RB_WR: begin
					state_q <= S_RB_RD1;
					idx_q   <= idx_q + kthanc_pkg::IDX_W'(1);
					if (idx_q == IDX_LAST) begin
						idx_q <= '0;
						if (lvl_q == LVL_TOP) begin
							stale_q <= 1'b0;
							state_q <= S_Q_STEP;
						end else begin
							lvl_q <= lvl_q + kthanc_pkg::LVL_W'(1);
						end
					end
				end
				S_Q_STEP: begin
					// walk step bits from the top down
					if (x_q == '0)
						state_q <= S_Q_DONE;
					else if (step_bit)
						state_q <= S_Q_LOAD;
					else if (lvl_q == '0)
						state_q <= S_Q_DONE;
					else
						lvl_q <= lvl_q - kthanc_pkg::LVL_W'(1);
				end
				S_Q_LOAD: begin
					x_q <= rd_data_q;
					if (lvl_q == '0) begin
						state_q <= S_Q_DONE;
					end else begin
						lvl_q   <= lvl_q - kthanc_pkg::LVL_W'(1);
						state_q <= S_Q_STEP;
					end
				end
				S_Q_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Rebuild finishing always leaves a current table
	a_rebuild_clears_stale: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RB_WR && idx_q == IDX_LAST && lvl_q == LVL_TOP)
		|=> (!stale_q && state_q == S_Q_STEP))
		else $error("rebuild end did not clear stale flag");

	// Query walk never reads the table for the empty node
	a_walk_no_null_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_Q_STEP && re) |-> (x_q != '0))
		else $error("table read for node zero");

	// Rebuild never overwrites loaded parents
	a_rebuild_level: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RB_WR || state_q == S_RB_RD1) |-> (lvl_q != '0))
		else $error("rebuild touched level zero");

	// A finished answer waits while the output is still occupied
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_Q_DONE && m_tvalid && !m_tready)
		|=> (state_q == S_Q_DONE && $stable(m_tdata)))
		else $error("answer dropped on stalled output");

	// Clearing pass covers every level-zero entry before service starts
	a_clear_length: assert property (@(posedge clk) disable iff (!arst_n)
		($past(state_q) == S_CLEAR && state_q == S_IDLE)
		|-> ($past(idx_q) == IDX_LAST))
		else $error("clearing pass ended early");

endmodule
